### hw/rtl/rfb_pkg.sv
// Shared types, constants and the microcode program of the radio frame builder.
package rfb_pkg;

   localparam int STORE_DEPTH = 32;
   localparam int SLOT_W = 5;
   localparam int UPC_W = 5;

   localparam logic [7:0] FRAME_START = 8'h7E;
   localparam logic [7:0] API_ID = 8'h01;
   localparam logic [7:0] FRAME_ID = 8'h01;
   localparam logic [7:0] TX_OPTIONS = 8'h00;
   localparam logic [7:0] LEN_HIGH = 8'h00;
   localparam logic [7:0] LEN_PAIR = 8'd7;
   localparam logic [7:0] LEN_CTRL = 8'd9;
   localparam int LEN_KEY_BASE = 6;

   // drive byte arithmetic
   localparam int PERIOD_MAX = 1000;
   localparam int PERIOD_MIN = 300;
   localparam int DRV_SPAN = 700;
   localparam int FWD_GAIN = 128;
   localparam int REV_GAIN = 127;
   localparam int DRV_MID = 127;
   localparam int RECIP = 1497;
   localparam int RECIP_SHIFT = 20;

   // register reset values
   localparam logic [15:0] RST_DEST = 16'd0;
   localparam logic [7:0] RST_TAG = 8'd0;
   localparam logic [7:0] RST_PAIRH = 8'd0;
   localparam logic [7:0] RST_KEYH = 8'd1;
   localparam logic [7:0] RST_CTRLH = 8'd2;
   localparam logic [7:0] RST_STRAIGHT = 8'd127;
   localparam logic [7:0] RST_LEFT = 8'd0;
   localparam logic [7:0] RST_RIGHT = 8'd255;

   typedef enum logic [2:0] {
      CSR_DEST     = 3'd0,
      CSR_TAG      = 3'd1,
      CSR_PAIRH    = 3'd2,
      CSR_KEYH     = 3'd3,
      CSR_CTRLH    = 3'd4,
      CSR_STRAIGHT = 3'd5,
      CSR_LEFT     = 3'd6,
      CSR_RIGHT    = 3'd7
   } csr_index_type;

   typedef enum logic {
      FUNC_SEND = 1'b0,
      FUNC_LOAD = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      PKT_PAIR = 2'd0,
      PKT_KEY  = 2'd1,
      PKT_CTRL = 2'd2,
      PKT_NONE = 2'd3
   } pkt_type;

   typedef enum logic [3:0] {
      SRC_LIT,
      SRC_LEN,
      SRC_DHI,
      SRC_DLO,
      SRC_PAIRH,
      SRC_TAG,
      SRC_KEYH,
      SRC_KEY,
      SRC_CTRLH,
      SRC_DRV,
      SRC_STR,
      SRC_FLG,
      SRC_CHK
   } src_type;

   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_DISPATCH,
      SEQ_LOOP,
      SEQ_JUMP,
      SEQ_END
   } seq_type;

   typedef struct packed {
      src_type           src;
      logic [7:0]        lit;
      logic              acc;
      logic              xkey;
      logic              kstep;
      seq_type           seq;
      logic [UPC_W-1:0]  target;
      logic              last;
   } ctrl_word_type;

   typedef struct packed {
      logic    start;
      logic    advance;
      logic    kend;
      pkt_type ptype;
   } seq_status_type;

   // program addresses
   localparam logic [UPC_W-1:0] UPC_START = 5'd0;
   localparam logic [UPC_W-1:0] UPC_ZERO  = 5'd1;
   localparam logic [UPC_W-1:0] UPC_LEN   = 5'd2;
   localparam logic [UPC_W-1:0] UPC_API   = 5'd3;
   localparam logic [UPC_W-1:0] UPC_FID   = 5'd4;
   localparam logic [UPC_W-1:0] UPC_DHI   = 5'd5;
   localparam logic [UPC_W-1:0] UPC_DLO   = 5'd6;
   localparam logic [UPC_W-1:0] UPC_OPT   = 5'd7;
   localparam logic [UPC_W-1:0] UPC_PAIR  = 5'd8;
   localparam logic [UPC_W-1:0] UPC_PTAG  = 5'd9;
   localparam logic [UPC_W-1:0] UPC_KEY   = 5'd10;
   localparam logic [UPC_W-1:0] UPC_KBYTE = 5'd11;
   localparam logic [UPC_W-1:0] UPC_CTRL  = 5'd12;
   localparam logic [UPC_W-1:0] UPC_CDRV  = 5'd13;
   localparam logic [UPC_W-1:0] UPC_CSTR  = 5'd14;
   localparam logic [UPC_W-1:0] UPC_CFLG  = 5'd15;
   localparam logic [UPC_W-1:0] UPC_CHK   = 5'd16;

   function automatic ctrl_word_type rfb_rom(input logic [UPC_W-1:0] upc);
      ctrl_word_type cw;
      cw = '0;
      cw.src = SRC_LIT;
      cw.seq = SEQ_NEXT;
      case (upc)
         UPC_START: cw.lit = FRAME_START;
         UPC_ZERO:  cw.lit = LEN_HIGH;
         UPC_LEN:   cw.src = SRC_LEN;
         UPC_API: begin
            cw.lit = API_ID;
            cw.acc = 1'b1;
         end
         UPC_FID: begin
            cw.lit = FRAME_ID;
            cw.acc = 1'b1;
         end
         UPC_DHI: begin
            cw.src = SRC_DHI;
            cw.acc = 1'b1;
         end
         UPC_DLO: begin
            cw.src = SRC_DLO;
            cw.acc = 1'b1;
         end
         UPC_OPT: begin
            cw.lit = TX_OPTIONS;
            cw.acc = 1'b1;
            cw.seq = SEQ_DISPATCH;
         end
         UPC_PAIR: begin
            cw.src = SRC_PAIRH;
            cw.acc = 1'b1;
         end
         UPC_PTAG: begin
            cw.src = SRC_TAG;
            cw.acc = 1'b1;
            cw.seq = SEQ_JUMP;
            cw.target = UPC_CHK;
         end
         UPC_KEY: begin
            cw.src = SRC_KEYH;
            cw.acc = 1'b1;
         end
         UPC_KBYTE: begin
            cw.src = SRC_KEY;
            cw.acc = 1'b1;
            cw.kstep = 1'b1;
            cw.seq = SEQ_LOOP;
            cw.target = UPC_CHK;
         end
         UPC_CTRL: begin
            cw.src = SRC_CTRLH;
            cw.acc = 1'b1;
            cw.xkey = 1'b1;
         end
         UPC_CDRV: begin
            cw.src = SRC_DRV;
            cw.acc = 1'b1;
            cw.xkey = 1'b1;
         end
         UPC_CSTR: begin
            cw.src = SRC_STR;
            cw.acc = 1'b1;
            cw.xkey = 1'b1;
         end
         UPC_CFLG: begin
            cw.src = SRC_FLG;
            cw.acc = 1'b1;
            cw.xkey = 1'b1;
         end
         UPC_CHK: begin
            cw.src = SRC_CHK;
            cw.seq = SEQ_END;
            cw.last = 1'b1;
         end
         default: begin
            cw.seq = SEQ_END;
            cw.last = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

### hw/rtl/radio_frame_builder_xor_keyed.sv
// Top level of the keyed radio transmit frame builder: registers, datapath, key store.
//
//  channel | ports                      | beat
//  --------+----------------------------+-------------------------------------
//  req     | req_tvalid/tready/tdata/tuser | one send or key-load item
//  rsp     | rsp_tvalid/tready/tdata/tlast | one frame byte, tlast on checksum
//  csr     | csr_we/index/wdata         | one register write
//
// A key load writes one key byte and its valid bit. A send is accepted and then takes
// one microcode step per frame byte: 11 for a pair request, 13 for control, and
// KEY_BYTES + 10 for a key frame. rsp_tready low with a byte held freezes the step
// counter. Synchronous reset presets the CSRs and clears key position and valid bits.
module radio_frame_builder_xor_keyed #(
   parameter int KEY_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // key_slot[4:0], key_byte[12:5], motion_period[28:13], reverse_on[29],
   // left_brake[30], right_brake[31], peripheral_pulse[32], zeros above
   input  logic [39:0] req_tdata,
   // func[0], packet_type[2:1]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tx_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   import rfb_pkg::*;

   localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam logic [7:0] LEN_KEY = 8'(KEY_BYTES + LEN_KEY_BASE);

   logic [15:0] dest_ff;
   logic [7:0]  tag_ff, pairh_ff, keyh_ff, ctrlh_ff, straight_ff, left_ff, right_ff;

   pkt_type     ptype_ff;
   logic [15:0] period_ff;
   logic        rev_ff, lb_ff, rb_ff, pulse_ff;

   logic [STORE_DEPTH-1:0] kvalid_in, kvalid_ff;
   logic [SLOT_W-1:0]      kpos_in, kpos_ff;
   logic [SLOT_W-1:0]      ptr_in, ptr_ff;
   logic [KW-1:0]          kcnt_in, kcnt_ff;
   logic [7:0]             sum_in, sum_ff;

   logic       rsp_valid_in, rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;

   logic            accept, load, start, adv, busy, kend, beyond;
   func_type        req_func;
   pkt_type         req_ptype;
   ctrl_word_type   cw;
   seq_status_type  status;
   logic [7:0]      ram_rdata, key_rd, key_val, steer, flags, drive, len, plain, byte_out;

   assign req_func = func_type'(req_tuser[0]);
   assign req_ptype = pkt_type'(req_tuser[2:1]);
   assign req_tready = !busy;
   assign accept = req_tvalid && !busy;
   assign load = accept && (req_func == FUNC_LOAD);
   assign start = accept && (req_func == FUNC_SEND) && (req_ptype != PKT_NONE);
   assign adv = busy && (!rsp_valid_ff || rsp_tready);
   assign kend = kcnt_ff == KW'(KEY_BYTES - 1);
   assign beyond = {{(7 - KW){1'b0}}, kcnt_ff} >= 7'(STORE_DEPTH);

   assign status = '{start: start, advance: adv, kend: kend, ptype: ptype_ff};

   rfb_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw),
      .busy   (busy)
   );

   rfb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (load),
      .waddr (req_tdata[4:0]),
      .wdata (req_tdata[12:5]),
      .raddr (ptr_in),
      .rdata (ram_rdata)
   );

   rfb_drive u_drive (
      .clock  (clock),
      .period (period_ff),
      .rev    (rev_ff),
      .drive  (drive)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff <= RST_DEST;
         tag_ff <= RST_TAG;
         pairh_ff <= RST_PAIRH;
         keyh_ff <= RST_KEYH;
         ctrlh_ff <= RST_CTRLH;
         straight_ff <= RST_STRAIGHT;
         left_ff <= RST_LEFT;
         right_ff <= RST_RIGHT;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEST:     dest_ff <= csr_wdata;
            CSR_TAG:      tag_ff <= csr_wdata[7:0];
            CSR_PAIRH:    pairh_ff <= csr_wdata[7:0];
            CSR_KEYH:     keyh_ff <= csr_wdata[7:0];
            CSR_CTRLH:    ctrlh_ff <= csr_wdata[7:0];
            CSR_STRAIGHT: straight_ff <= csr_wdata[7:0];
            CSR_LEFT:     left_ff <= csr_wdata[7:0];
            CSR_RIGHT:    right_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ptype_ff <= req_ptype;
         period_ff <= req_tdata[28:13];
         rev_ff <= req_tdata[29];
         lb_ff <= req_tdata[30];
         rb_ff <= req_tdata[31];
         pulse_ff <= req_tdata[32];
      end
   end

   // byte datapath
   always_comb begin
      key_rd = kvalid_ff[ptr_ff] ? ram_rdata : 8'd0;
      key_val = beyond ? 8'd0 : key_rd;
      if (lb_ff && rb_ff) begin
         steer = straight_ff;
      end else if (rb_ff) begin
         steer = right_ff;
      end else if (lb_ff) begin
         steer = left_ff;
      end else begin
         steer = straight_ff;
      end
      flags = {6'b0, lb_ff && rb_ff, pulse_ff};
      case (ptype_ff)
         PKT_PAIR: len = LEN_PAIR;
         PKT_KEY:  len = LEN_KEY;
         default:  len = LEN_CTRL;
      endcase
      case (cw.src)
         SRC_LIT:   plain = cw.lit;
         SRC_LEN:   plain = len;
         SRC_DHI:   plain = dest_ff[15:8];
         SRC_DLO:   plain = dest_ff[7:0];
         SRC_PAIRH: plain = pairh_ff;
         SRC_TAG:   plain = tag_ff;
         SRC_KEYH:  plain = keyh_ff;
         SRC_KEY:   plain = key_val;
         SRC_CTRLH: plain = ctrlh_ff;
         SRC_DRV:   plain = drive;
         SRC_STR:   plain = steer;
         SRC_FLG:   plain = flags;
         SRC_CHK:   plain = ~sum_ff;
         default:   plain = 8'd0;
      endcase
      byte_out = cw.xkey ? (plain ^ key_rd) : plain;
   end

   // key pointers, checksum and key valid bits
   always_comb begin
      ptr_in = ptr_ff;
      kcnt_in = kcnt_ff;
      kpos_in = kpos_ff;
      sum_in = sum_ff;
      kvalid_in = kvalid_ff;
      if (load) begin
         kvalid_in[req_tdata[4:0]] = 1'b1;
      end
      if (start) begin
         sum_in = 8'd0;
      end else if (adv) begin
         if (cw.acc) begin
            sum_in = sum_ff + byte_out;
         end
         if (cw.seq == SEQ_DISPATCH) begin
            ptr_in = (ptype_ff == PKT_KEY) ? '0 : kpos_ff;
            kcnt_in = '0;
         end
         if (cw.xkey || cw.kstep) begin
            ptr_in = ptr_ff + 5'd1;
         end
         if (cw.kstep) begin
            kcnt_in = kcnt_ff + KW'(1);
         end
         if (cw.seq == SEQ_END) begin
            case (ptype_ff)
               PKT_KEY:  kpos_in = '0;
               PKT_CTRL: kpos_in = ptr_ff;
               default:  kpos_in = kpos_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kvalid_ff <= '0;
         kpos_ff <= '0;
         ptr_ff <= '0;
         kcnt_ff <= '0;
      end else begin
         kvalid_ff <= kvalid_in;
         kpos_ff <= kpos_in;
         ptr_ff <= ptr_in;
         kcnt_ff <= kcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= byte_out;
         rsp_last_ff <= cw.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

### hw/rtl/rfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/rfb_drive.sv
// Pipelined drive byte unit: clamp, scale and divide by the period span.
module rfb_drive (
   input  logic        clock,
   input  logic [15:0] period,
   input  logic        rev,
   output logic [7:0]  drive
);

   import rfb_pkg::*;

   logic [9:0]  pc;
   logic [9:0]  x;
   logic [16:0] n1_in, n1_ff;
   logic [16:0] n2_ff;
   logic [27:0] m2_in, m2_ff;
   logic [7:0]  q3_ff;
   logic [16:0] n3_ff;
   logic [16:0] rem;
   logic [7:0]  q;
   logic        sat;
   logic [7:0]  drive_in, drive_ff;

   always_comb begin
      pc = (period > 16'(PERIOD_MAX)) ? 10'(PERIOD_MAX) : period[9:0];
      x = 10'(PERIOD_MAX) - pc;
      n1_in = rev ? 17'({7'b0, x}) * 17'(REV_GAIN) : 17'({7'b0, x}) * 17'(FWD_GAIN);
      m2_in = 28'({11'b0, n1_ff}) * 28'(RECIP);
      // reciprocal estimate is low by at most one
      rem = n3_ff - 17'({9'b0, q3_ff}) * 17'(DRV_SPAN);
      q = q3_ff + ((rem >= 17'(DRV_SPAN)) ? 8'd1 : 8'd0);
      sat = period < 16'(PERIOD_MIN);
      if (sat) begin
         drive_in = rev ? 8'd0 : 8'd255;
      end else begin
         drive_in = rev ? 8'(DRV_MID) - q : q + 8'(DRV_MID);
      end
   end

   always_ff @(posedge clock) begin
      n1_ff <= n1_in;
      n2_ff <= n1_ff;
      m2_ff <= m2_in;
      q3_ff <= m2_ff[RECIP_SHIFT +: 8];
      n3_ff <= n2_ff;
      drive_ff <= drive_in;
   end

   assign drive = drive_ff;

endmodule

### hw/rtl/rfb_sequencer.sv
// Microcode sequencer: step counter, program lookup and jump logic.
module rfb_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  rfb_pkg::seq_status_type status,
   output rfb_pkg::ctrl_word_type  cw,
   output logic                   busy
);

   import rfb_pkg::*;

   logic [UPC_W-1:0] upc_in, upc_ff;
   logic             busy_in, busy_ff;

   assign cw = rfb_rom(upc_ff);

   always_comb begin
      upc_in = upc_ff;
      busy_in = busy_ff;
      if (status.start) begin
         busy_in = 1'b1;
         upc_in = UPC_START;
      end else if (busy_ff && status.advance) begin
         case (cw.seq)
            SEQ_NEXT: upc_in = upc_ff + 5'd1;
            SEQ_DISPATCH: begin
               case (status.ptype)
                  PKT_PAIR: upc_in = UPC_PAIR;
                  PKT_KEY:  upc_in = UPC_KEY;
                  default:  upc_in = UPC_CTRL;
               endcase
            end
            SEQ_LOOP: upc_in = status.kend ? cw.target : upc_ff;
            SEQ_JUMP: upc_in = cw.target;
            default: begin
               busy_in = 1'b0;
               upc_in = UPC_START;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_START;
         busy_ff <= 1'b0;
      end else begin
         upc_ff <= upc_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule
